// ----- src/dfq_pkg.sv -----
// Shared types and codes for the duplicate-rejecting FIFO queue.
// No dependencies; compile first.
package dfq_pkg;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned OCC_W  = 8;
	localparam int unsigned LANES  = 16;

endpackage

// ----- src/dfq_if.sv -----
// Valid/ready channel interfaces for request and response transfers.
// Depends on dfq_pkg.
interface dfq_req_if;
	import dfq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface dfq_rsp_if;
	import dfq_pkg::*;

	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DATA_W-1:0] removed_value;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, output status, output removed_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input removed_value, input occupancy,
		output ready);
endinterface

// ----- src/dedup_fifo_queue.sv -----
// Top level of the duplicate-rejecting FIFO queue: sequencer, ring pointers,
// lane RAMs and output register. Depends on dfq_pkg, dfq_if, dfq_ram, dfq_match.
//
// Usage: requests arrive on req (req_type 0 enqueue value, 1 dequeue); each
// produces exactly one response on rsp with status, removed_value and the
// occupancy after the request.
// The store is split into LANES RAMs; one row of LANES entries is read per
// cycle and checked by a single compare unit, so an enqueue scans all
// ROWS = ceil(DEPTH/LANES) rows in SCAN, then passes LAST and FIN before the
// response is loaded, and a new request may enter the cycle after.
// A dequeue passes RD (one RAM read) and LAST; an empty dequeue skips to FIN.
// req.ready is high only while the sequencer is idle. The response sits in
// an output register; a new request is taken while it waits, and its result
// is held back until the receiver takes the earlier one.
// Reset clears the ring pointers, the count and the sequencer; the store
// needs no clearing because only held entries are ever compared or read.
module dedup_fifo_queue #(
	parameter int unsigned DEPTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	dfq_req_if.sink   req,
	dfq_rsp_if.source rsp
);
	import dfq_pkg::*;

	localparam int unsigned ROWS   = (DEPTH + LANES - 1) / LANES;
	localparam int unsigned ROW_W  = ROWS > 1 ? $clog2(ROWS) : 1;
	localparam int unsigned LANE_W = $clog2(LANES);
	localparam int unsigned POS_W  = ROW_W + LANE_W;
	localparam int unsigned PTR_W  = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		RD,
		LAST,
		FIN
	} state_t;

	state_t                   state_q;
	logic                     req_type_q;
	logic [DATA_W-1:0]        value_q;
	logic                     dup_q;
	logic [DATA_W-1:0]        rem_q;
	logic [ROW_W-1:0]         row_q;
	logic [PTR_W-1:0]         head_q;
	logic [CNT_W-1:0]         count_q;
	logic                     rd_vld_s1;
	logic [ROW_W-1:0]         row_s1;
	logic                     rsp_valid_q;
	status_t                  status_q;
	logic [DATA_W-1:0]        removed_q;
	logic [OCC_W-1:0]         occ_q;

	logic [LANES-1:0][DATA_W-1:0] row_data;
	logic                     rd_en;
	logic [ROW_W-1:0]         rd_addr;
	logic                     hit;
	logic                     fin_go;
	logic [POS_W-1:0]         head_ext;
	logic [POS_W-1:0]         tail_ext;
	logic [CNT_W:0]           tail_sum;
	logic [PTR_W-1:0]         tail_pos;
	logic [PTR_W-1:0]         head_inc;
	logic                     enq_ok;
	logic                     deq_ok;
	status_t                  status_d;
	logic [CNT_W-1:0]         count_d;
	logic [LANES-1:0]         lane_we;

	assign head_ext = POS_W'(head_q);
	assign tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
	assign tail_pos = (tail_sum >= (CNT_W+1)'(DEPTH)) ?
		PTR_W'(tail_sum - (CNT_W+1)'(DEPTH)) : PTR_W'(tail_sum);
	assign tail_ext = POS_W'(tail_pos);
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	assign rd_en   = (state_q == SCAN) || (state_q == RD);
	assign rd_addr = (state_q == RD) ? head_ext[POS_W-1:LANE_W] : row_q;
	assign fin_go  = (state_q == FIN) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		enq_ok   = 1'b0;
		deq_ok   = 1'b0;
		status_d = ST_DONE;
		count_d  = count_q;
		if (req_type_q == REQ_DEQ) begin
			if (count_q == '0) begin
				status_d = ST_EMPTY;
			end else begin
				deq_ok  = 1'b1;
				count_d = count_q - CNT_W'(1);
			end
		end else begin
			if (dup_q) begin
				status_d = ST_DUP;
			end else if (count_q == CNT_W'(DEPTH)) begin
				status_d = ST_FULL;
			end else begin
				enq_ok  = 1'b1;
				count_d = count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_we[l] = fin_go && enq_ok && (tail_ext[LANE_W-1:0] == LANE_W'(l));
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		dfq_ram #(
			.WIDTH(DATA_W),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (lane_we[l]),
			.waddr(tail_ext[POS_W-1:LANE_W]),
			.wdata(value_q),
			.re   (rd_en),
			.raddr(rd_addr),
			.rdata(row_data[l])
		);
	end

	dfq_match #(
		.DEPTH(DEPTH)
	) u_match (
		.row_data(row_data),
		.row     (row_s1),
		.value   (value_q),
		.head    (head_q),
		.count   (count_q),
		.hit     (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_DONE;
			removed_q   <= '0;
			occ_q       <= '0;
			row_q       <= '0;
			dup_q       <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rsp_valid_q && rsp.ready && !fin_go) begin
				rsp_valid_q <= 1'b0;
			end
			if (rd_vld_s1 && hit) begin
				dup_q <= 1'b1;
			end
			case (state_q)
				IDLE: begin
					if (req.valid) begin
						row_q <= '0;
						dup_q <= 1'b0;
						if (req.req_type == REQ_DEQ) begin
							state_q <= (count_q == '0) ? FIN : RD;
						end else begin
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					row_q <= row_q + ROW_W'(1);
					if (row_q == ROW_W'(ROWS - 1)) begin
						state_q <= LAST;
					end
				end
				RD: begin
					state_q <= LAST;
				end
				LAST: begin
					state_q <= FIN;
				end
				FIN: begin
					if (fin_go) begin
						rsp_valid_q <= 1'b1;
						status_q    <= status_d;
						removed_q   <= deq_ok ? rem_q : '0;
						occ_q       <= OCC_W'(count_d);
						count_q     <= count_d;
						if (deq_ok) begin
							head_q <= head_inc;
						end
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= rd_addr;
		if (state_q == IDLE && req.valid) begin
			req_type_q <= req.req_type;
			value_q    <= req.value;
		end
		if (state_q == LAST) begin
			rem_q <= row_data[head_ext[LANE_W-1:0]];
		end
	end

	assign req.ready         = (state_q == IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q;
	assign rsp.occupancy     = occ_q;

endmodule

// ----- src/dfq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/dfq_match.sv -----
// Shared compare unit: tests one store row against the search value, masking
// lanes outside the held ring span. Depends on dfq_pkg.
module dfq_match #(
	parameter int unsigned DEPTH = 128
) (
	input  logic [dfq_pkg::LANES-1:0][dfq_pkg::DATA_W-1:0]                row_data,
	input  logic [((DEPTH+dfq_pkg::LANES-1)/dfq_pkg::LANES > 1 ?
		$clog2((DEPTH+dfq_pkg::LANES-1)/dfq_pkg::LANES) : 1)-1:0]       row,
	input  logic [dfq_pkg::DATA_W-1:0]                                   value,
	input  logic [$clog2(DEPTH)-1:0]                                     head,
	input  logic [$clog2(DEPTH+1)-1:0]                                   count,
	output logic                                                         hit
);
	import dfq_pkg::*;

	localparam int unsigned ROWS   = (DEPTH + LANES - 1) / LANES;
	localparam int unsigned ROW_W  = ROWS > 1 ? $clog2(ROWS) : 1;
	localparam int unsigned LANE_W = $clog2(LANES);
	localparam int unsigned POS_W  = ROW_W + LANE_W;

	logic [POS_W:0]     pos_x  [LANES];
	logic [POS_W:0]     off_x  [LANES];
	logic [LANES-1:0]   held;
	logic [LANES-1:0]   eq;
	logic [POS_W:0]     head_x;
	logic [POS_W:0]     cnt_x;

	assign head_x = (POS_W+1)'(head);
	assign cnt_x  = (POS_W+1)'(count);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			pos_x[l] = (POS_W+1)'({row, LANE_W'(l)});
			if (pos_x[l] >= head_x) begin
				off_x[l] = pos_x[l] - head_x;
			end else begin
				off_x[l] = pos_x[l] + (POS_W+1)'(DEPTH) - head_x;
			end
			held[l] = (pos_x[l] < (POS_W+1)'(DEPTH)) && (off_x[l] < cnt_x);
			eq[l]   = (row_data[l] == value);
		end
	end

	assign hit = |(held & eq);

endmodule

// ----- src/dfq_checker.sv -----
// Port-level checks for dedup_fifo_queue, attached by bind.
// Depends on dfq_pkg and dedup_fifo_queue.
module dfq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [1:0]                    status,
	input logic [dfq_pkg::DATA_W-1:0]    removed_value,
	input logic [dfq_pkg::OCC_W-1:0]     occupancy
);
	import dfq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
		$stable(removed_value) && $stable(occupancy))
		else $error("response changed while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in work");

	a_zero_removed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_DONE |-> removed_value == '0)
		else $error("rejected request returned a value");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> occupancy == '0)
		else $error("empty status with nonzero occupancy");

endmodule

bind dedup_fifo_queue dfq_checker u_dfq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.removed_value(rsp.removed_value),
	.occupancy    (rsp.occupancy)
);
